// File: src/dsefr_pkg.sv
// ----------------------------------------------------------------------------
// dsefr_pkg
// shared constants and types for the dle/stx/etx frame receiver
// ----------------------------------------------------------------------------
package dsefr_pkg;

  // framing characters
  localparam logic [7:0] CHR_DLE = 8'h10;
  localparam logic [7:0] CHR_STX = 8'h02;
  localparam logic [7:0] CHR_ETX = 8'h03;

  // frame length limit
  localparam logic [7:0] LIMIT_MIN   = 8'd4;
  localparam logic [7:0] LIMIT_MAX   = 8'd254;
  localparam logic [7:0] LIMIT_RESET = 8'd254;

  // result status codes
  localparam logic [1:0] STATUS_DATA  = 2'd0;
  localparam logic [1:0] STATUS_END   = 2'd1;
  localparam logic [1:0] STATUS_ABORT = 2'd2;

  // result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [1:0] status;
    logic [7:0] frame_length;
  } result_t;

  // up to two results caused by one received byte
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

endpackage

// File: src/dsefr_byte_if.sv
// ----------------------------------------------------------------------------
// dsefr_byte_if
// received byte stream channel
// ----------------------------------------------------------------------------
interface dsefr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: src/dsefr_result_if.sv
// ----------------------------------------------------------------------------
// dsefr_result_if
// frame result channel
// ----------------------------------------------------------------------------
interface dsefr_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [1:0] status;
  logic [7:0] frame_length;

  modport source (output valid, output frame_byte, output status, output frame_length,
                  input ready);
  modport sink (input valid, input frame_byte, input status, input frame_length,
                output ready);
endinterface

// File: src/dsefr_cfg_if.sv
// ----------------------------------------------------------------------------
// dsefr_cfg_if
// configuration write channel for the frame length limit
// ----------------------------------------------------------------------------
interface dsefr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] max_frame_len;

  modport source (output valid, output max_frame_len, input ready);
  modport sink (input valid, input max_frame_len, output ready);
endinterface

// File: src/dsefr_decoder.sv
// ----------------------------------------------------------------------------
// dsefr_decoder
// framing state and per-byte decode into up to two results
// ----------------------------------------------------------------------------
module dsefr_decoder
  import dsefr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  logic [7:0]   rx_byte,
  input  logic [7:0]   max_frame_len,
  output result_pair_t pair
);

  logic       in_frame;
  logic       dle_pending;
  logic [7:0] byte_count;

  logic       in_frame_next;
  logic       dle_pending_next;
  logic [7:0] byte_count_next;
  logic [7:0] limit;
  logic [7:0] count_inc;

  always_comb begin
    limit = max_frame_len;
    if (max_frame_len < LIMIT_MIN) begin
      limit = LIMIT_MIN;
    end else if (max_frame_len > LIMIT_MAX) begin
      limit = LIMIT_MAX;
    end
  end

  assign count_inc = byte_count + 8'd1;

  always_comb begin
    in_frame_next    = in_frame;
    dle_pending_next = dle_pending;
    byte_count_next  = byte_count;
    pair.count  = 2'd0;
    pair.first  = '{frame_byte: rx_byte, status: STATUS_DATA, frame_length: count_inc};
    pair.second = '{frame_byte: CHR_STX, status: STATUS_DATA, frame_length: 8'd2};

    if (!in_frame) begin
      if (rx_byte == CHR_DLE) begin
        dle_pending_next = !dle_pending;
      end else if (rx_byte == CHR_STX && dle_pending) begin
        // header found: replay both header bytes
        in_frame_next    = 1'b1;
        dle_pending_next = 1'b0;
        byte_count_next  = 8'd2;
        pair.count       = 2'd2;
        pair.first       = '{frame_byte: CHR_DLE, status: STATUS_DATA, frame_length: 8'd1};
      end else begin
        dle_pending_next = 1'b0;
      end
    end else if (byte_count >= limit) begin
      // overflow abandons the frame, byte is dropped
      pair.count       = 2'd1;
      pair.first       = '{frame_byte: rx_byte, status: STATUS_ABORT,
                           frame_length: byte_count};
      in_frame_next    = 1'b0;
      dle_pending_next = 1'b0;
      byte_count_next  = 8'd0;
    end else begin
      pair.count      = 2'd1;
      byte_count_next = count_inc;
      if (rx_byte == CHR_DLE) begin
        dle_pending_next = !dle_pending;
      end else if (rx_byte == CHR_ETX && dle_pending) begin
        pair.first.status = STATUS_END;
        in_frame_next     = 1'b0;
        dle_pending_next  = 1'b0;
        byte_count_next   = 8'd0;
      end else begin
        dle_pending_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      dle_pending <= 1'b0;
      byte_count  <= 8'd0;
    end else if (advance) begin
      in_frame    <= in_frame_next;
      dle_pending <= dle_pending_next;
      byte_count  <= byte_count_next;
    end
  end

endmodule

// File: src/dsefr_fifo.sv
// ----------------------------------------------------------------------------
// dsefr_fifo
// small result queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module dsefr_fifo
  import dsefr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push_en,
  input  result_pair_t pair,
  input  logic         pop,
  output result_t      head,
  output logic         not_empty,
  output logic         has_room
);

  result_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   count;
  logic [1:0]           push_n;
  logic [FIFO_AW-1:0]   wr_ptr_second;

  assign push_n        = push_en ? pair.count : 2'd0;
  assign wr_ptr_second = wr_ptr + FIFO_AW'(1);
  assign not_empty     = (count != '0);
  assign has_room      = (count <= FIFO_CW'(FIFO_DEPTH - 2));
  assign head          = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= pair.first;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_second] <= pair.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + FIFO_CW'(push_n) - FIFO_CW'(pop);
    end
  end

endmodule

// File: src/dle_stx_etx_frame_receiver.sv
// ----------------------------------------------------------------------------
// dle_stx_etx_frame_receiver
// finds dle/stx ... dle/etx frames in a byte stream and forwards their bytes
// ----------------------------------------------------------------------------
// path: the input register, then the result queue once it has room for two results
// throughput: one byte per cycle while the result queue has room; a frame header
//   byte adds one extra result that drains through the four-entry result queue
// reset: rst is synchronous, returns to hunting with the limit at 254
// ----------------------------------------------------------------------------
module dle_stx_etx_frame_receiver
  import dsefr_pkg::*;
(
  input logic          clk,
  input logic          rst,
  dsefr_byte_if.sink   rx,
  dsefr_result_if.source frame,
  dsefr_cfg_if.sink    cfg
);

  // frame length limit register, always ready for a write
  logic [7:0] max_frame_len;

  // input register holding one accepted byte
  logic       in_q_valid;
  logic [7:0] in_q_byte;

  // decode and queue
  result_pair_t pair;
  result_t      head;
  logic         not_empty;
  logic         has_room;
  logic         advance;
  logic         pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= LIMIT_RESET;
    end else if (cfg.valid) begin
      max_frame_len <= cfg.max_frame_len;
    end
  end

  // the held byte moves on once the queue can take two results
  assign advance  = in_q_valid && has_room;
  assign rx.ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (rx.ready) begin
      in_q_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_q_byte <= rx.rx_byte;
    end
  end

  dsefr_decoder u_decoder (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .rx_byte       (in_q_byte),
    .max_frame_len (max_frame_len),
    .pair          (pair)
  );

  // results leave one per request
  assign pop = frame.valid && frame.ready;

  dsefr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_en   (advance),
    .pair      (pair),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .has_room  (has_room)
  );

  assign frame.valid        = not_empty;
  assign frame.frame_byte   = head.frame_byte;
  assign frame.status       = head.status;
  assign frame.frame_length = head.frame_length;

`ifndef SYNTHESIS
  // nothing is offered right after reset
  assert property (@(posedge clk) $past(rst) |-> !frame.valid)
    else $error("result offered right after reset");

  // a held byte is kept until the queue takes its results
  assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !advance |=> in_q_valid && $stable(in_q_byte))
    else $error("held byte lost while waiting for queue room");

  // a pair of results only comes from a frame header
  assert property (@(posedge clk) disable iff (rst)
    advance && pair.count == 2'd2 |-> in_q_byte == CHR_STX && pair.first.frame_byte == CHR_DLE)
    else $error("two results from a byte that is not a header");
`endif

endmodule

// File: verif/dle_stx_etx_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// dle_stx_etx_frame_receiver_tb
// self-checking bench for the dle/stx/etx frame receiver: a directed table
// walks header, stuffing, trailer and overflow cases, then random phases of
// mostly well-formed frames run under several length limits while both
// channels idle and stall; every accepted result is checked against a
// cycle-free model of the frame hunter
// ----------------------------------------------------------------------------
module dle_stx_etx_frame_receiver_tb;
  import dsefr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS  = 1750;  // bytes that the block acts on
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT   = 1000;
  localparam int STALL_LIMIT   = 2000;  // cycles with no request moving
  localparam int REPORT_MAX    = 10;

  localparam result_t NO_RES = '0;

  typedef enum int {SINK_FREE, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

  // one directed step: a received byte or a write of the length limit;
  // typed rows carry their results, the others go through the model
  typedef struct packed {
    bit         is_cfg;
    logic [7:0] value;
    bit         typed;
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } stim_row_t;

  localparam int DIR_ROWS = 29;

  stim_row_t dir_tab [DIR_ROWS] = '{
    // after reset: hunting drops plain bytes and a bare stx
    '{1'b0, 8'h00,   1'b1, 2'd0, NO_RES, NO_RES},
    '{1'b0, 8'hff,   1'b1, 2'd0, NO_RES, NO_RES},
    '{1'b0, CHR_STX, 1'b1, 2'd0, NO_RES, NO_RES},
    // doubled dle while hunting cancels itself, so no header
    '{1'b0, CHR_DLE, 1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, CHR_DLE, 1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, CHR_STX, 1'b1, 2'd0, NO_RES, NO_RES},
    // real header: both bytes come out
    '{1'b0, CHR_DLE, 1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, CHR_STX, 1'b1, 2'd2, '{CHR_DLE, STATUS_DATA, 8'd1},
                                 '{CHR_STX, STATUS_DATA, 8'd2}},
    // payload extremes, stuffed dle, etx behind a stuffed dle
    '{1'b0, 8'h00,   1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, 8'hff,   1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, CHR_DLE, 1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, CHR_DLE, 1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, CHR_ETX, 1'b0, 2'd0, NO_RES, NO_RES},
    // lone dle followed by a plain byte clears the escape
    '{1'b0, CHR_DLE, 1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, 8'h55,   1'b0, 2'd0, NO_RES, NO_RES},
    // trailer
    '{1'b0, CHR_DLE, 1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, CHR_ETX, 1'b1, 2'd1, '{CHR_ETX, STATUS_END, 8'd11}, NO_RES},
    // limit below the floor acts as four: fifth byte overflows
    '{1'b1, 8'h00,   1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, CHR_DLE, 1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, CHR_STX, 1'b1, 2'd2, '{CHR_DLE, STATUS_DATA, 8'd1},
                                 '{CHR_STX, STATUS_DATA, 8'd2}},
    '{1'b0, 8'haa,   1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, 8'hbb,   1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, 8'hcc,   1'b1, 2'd1, '{8'hcc, STATUS_ABORT, 8'd4}, NO_RES},
    '{1'b0, CHR_ETX, 1'b1, 2'd0, NO_RES, NO_RES},
    // limit above the ceiling, then the shortest complete frame
    '{1'b1, 8'hff,   1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, CHR_DLE, 1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, CHR_STX, 1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, CHR_DLE, 1'b0, 2'd0, NO_RES, NO_RES},
    '{1'b0, CHR_ETX, 1'b1, 2'd1, '{CHR_ETX, STATUS_END, 8'd4}, NO_RES}
  };

  logic clk;
  logic rst;

  dsefr_byte_if   rx_if ();
  dsefr_result_if res_if ();
  dsefr_cfg_if    cfg_if ();

  dle_stx_etx_frame_receiver dut (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx_if),
    .frame (res_if),
    .cfg   (cfg_if)
  );

  // model of the frame hunter
  logic [7:0] cur_limit;
  logic       trk_in_frame;
  logic       trk_dle;
  logic [7:0] trk_count;

  result_t pending_results [$];  // frame results still owed by the block
  int      error_count;
  int      bytes_accepted;       // every byte request taken by the block

  // what the driver says about the byte it is offering right now
  bit         row_typed;
  logic [1:0] row_n;
  result_t    row_r0;
  result_t    row_r1;

  int burst_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // advances the model by one received byte; returns how many results
  function automatic int decode_byte(input logic [7:0] b, output result_t r0,
                                     output result_t r1);
    logic [7:0] lim;
    r0 = NO_RES;
    r1 = NO_RES;
    lim = cur_limit;
    if (lim < LIMIT_MIN) lim = LIMIT_MIN;
    if (lim > LIMIT_MAX) lim = LIMIT_MAX;

    // hunting: only an unescaped dle then stx opens a frame
    if (!trk_in_frame) begin
      if (b == CHR_DLE) begin
        trk_dle = !trk_dle;
        return 0;
      end
      if (b == CHR_STX && trk_dle) begin
        trk_in_frame = 1'b1;
        trk_dle = 1'b0;
        trk_count = 8'd2;
        r0 = '{CHR_DLE, STATUS_DATA, 8'd1};
        r1 = '{CHR_STX, STATUS_DATA, 8'd2};
        return 2;
      end
      trk_dle = 1'b0;
      return 0;
    end

    // frame already full: this byte is rejected and the frame dropped
    if (trk_count >= lim) begin
      r0 = '{b, STATUS_ABORT, trk_count};
      trk_in_frame = 1'b0;
      trk_dle = 1'b0;
      trk_count = 8'd0;
      return 1;
    end

    trk_count = trk_count + 8'd1;
    if (b == CHR_DLE) begin
      trk_dle = !trk_dle;
      r0 = '{b, STATUS_DATA, trk_count};
      return 1;
    end
    if (b == CHR_ETX && trk_dle) begin
      r0 = '{b, STATUS_END, trk_count};
      trk_in_frame = 1'b0;
      trk_dle = 1'b0;
      trk_count = 8'd0;
      return 1;
    end
    trk_dle = 1'b0;
    r0 = '{b, STATUS_DATA, trk_count};
    return 1;
  endfunction

  function automatic void flag_result(input string what, input result_t want,
                                      input result_t got);
    error_count++;
    if (error_count <= REPORT_MAX)
      $display("%0t %s: want byte %h status %0d len %0d, got byte %h status %0d len %0d",
               $realtime, what, want.frame_byte, want.status, want.frame_length,
               got.frame_byte, got.status, got.frame_length);
  endfunction

  // sampling at the rising edge: limit writes, byte requests, result requests
  result_t got_res;
  result_t want_res;
  result_t next0;
  result_t next1;
  int      n_pred;

  always @(posedge clk) begin
    if (rst) begin
      cur_limit = LIMIT_RESET;
      trk_in_frame = 1'b0;
      trk_dle = 1'b0;
      trk_count = 8'd0;
      pending_results.delete();
    end else begin
      if (res_if.valid && res_if.ready) begin
        got_res = '{res_if.frame_byte, res_if.status, res_if.frame_length};
        if (pending_results.size() == 0) begin
          flag_result("result with nothing owed", NO_RES, got_res);
        end else begin
          want_res = pending_results.pop_front();
          if (got_res.frame_byte !== want_res.frame_byte ||
              got_res.status !== want_res.status ||
              got_res.frame_length !== want_res.frame_length)
            flag_result("wrong result", want_res, got_res);
        end
      end

      if (cfg_if.valid && cfg_if.ready)
        cur_limit = cfg_if.max_frame_len;

      if (rx_if.valid && rx_if.ready) begin
        bytes_accepted++;
        n_pred = decode_byte(rx_if.rx_byte, next0, next1);
        // table rows with typed results replace what the model gives
        if (row_typed) begin
          n_pred = int'(row_n);
          next0 = row_r0;
          next1 = row_r1;
        end
        if (n_pred > 0) pending_results.push_back(next0);
        if (n_pred > 1) pending_results.push_back(next1);
      end
    end
  end

  // result side: free running, random ready draws, or a repeating stall pattern
  initial begin : sink_stall
    sink_mode_t mode;
    int         mode_left;
    logic [7:0] pat;
    logic [2:0] pos;
    res_if.ready = 1'b0;
    mode = SINK_FREE;
    mode_left = 0;
    pat = 8'hff;
    pos = 3'd0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 160);
        pat = 8'($urandom_range(1, 255));  // never all stall
      end
      mode_left--;
      pos = pos + 3'd1;
      case (mode)
        SINK_FREE: res_if.ready <= 1'b1;
        SINK_RANDOM: res_if.ready <= ($urandom_range(0, 2) != 0);
        default: res_if.ready <= pat[pos];
      endcase
    end
  end

  // no request of any kind for too long means the block hung
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("dle_stx_etx_frame_receiver: mismatch");
    $finish;
  end

  // offers one byte in bursts with gaps between them, holds until taken
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input logic [1:0] n = 2'd0, input result_t r0 = NO_RES,
                           input result_t r1 = NO_RES);
    int gap;
    if (burst_left == 0) begin
      // some bursts are long, so stretches with no idling occur
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      @(negedge clk);
      rx_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    row_typed = typed;
    row_n = n;
    row_r0 = r0;
    row_r1 = r1;
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    burst_left--;
  endtask

  // sender holds off until every owed result is in and the pipe is empty
  task automatic wait_drained();
    @(negedge clk);
    rx_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    wait_drained();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.max_frame_len <= v;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // payload bytes lean on the framing characters
  function automatic logic [7:0] data_byte();
    case ($urandom_range(0, 7))
      0, 1: return CHR_DLE;
      2: return CHR_STX;
      3: return CHR_ETX;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // clean frames stuff every data dle and close with dle etx; broken ones
  // may leave a dle unstuffed or never close
  task automatic send_frame(input bit clean);
    int         len;
    logic [7:0] b;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 260)
                                       : $urandom_range(0, 20);
    repeat ($urandom_range(0, 2)) begin
      b = 8'($urandom_range(0, 255));
      if (clean && b == CHR_DLE) b = 8'h00;
      send_byte(b);
    end
    send_byte(CHR_DLE);
    send_byte(CHR_STX);
    for (int i = 0; i < len; i++) begin
      b = data_byte();
      send_byte(b);
      if (b == CHR_DLE && (clean || $urandom_range(0, 3) != 0)) send_byte(CHR_DLE);
    end
    if (clean || $urandom_range(0, 1) == 0) begin
      send_byte(CHR_DLE);
      send_byte(CHR_ETX);
    end
  endtask

  initial begin : stimulus
    int         phase;
    int         phase_end;
    int         pick;
    logic [7:0] lim;
    rst = 1'b1;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = 8'h00;
    cfg_if.valid = 1'b0;
    cfg_if.max_frame_len = 8'h00;
    row_typed = 1'b0;
    row_n = 2'd0;
    row_r0 = NO_RES;
    row_r1 = NO_RES;
    error_count = 0;
    bytes_accepted = 0;
    burst_left = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].is_cfg)
        write_limit(dir_tab[i].value);
      else
        send_byte(dir_tab[i].value, dir_tab[i].typed, dir_tab[i].n,
                  dir_tab[i].r0, dir_tab[i].r1);
    end

    // random phases, each under its own limit; the first few hit the
    // extremes, later ones favor small limits so overflow stays common
    phase = 0;
    while (bytes_accepted < RANDOM_ITEMS) begin
      case (phase)
        0: lim = 8'd0;
        1: lim = 8'd255;
        2: lim = LIMIT_MIN;
        3: lim = LIMIT_MAX;
        4: lim = 8'd3;
        default: begin
          pick = $urandom_range(0, 9);
          if (pick < 6) lim = 8'($urandom_range(4, 24));
          else if (pick < 8) lim = 8'($urandom_range(0, 255));
          else lim = ($urandom_range(0, 1) == 0) ? LIMIT_MIN : LIMIT_MAX;
        end
      endcase
      write_limit(lim);
      phase++;
      phase_end = bytes_accepted + $urandom_range(60, 220);
      while (bytes_accepted < phase_end && bytes_accepted < RANDOM_ITEMS) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, 12)) send_byte(data_byte());  // line noise
          1: send_frame(1'b0);
          default: send_frame(1'b1);
        endcase
        if ($urandom_range(0, 29) == 0) wait_drained();
      end
    end

    // wind down: let owed results arrive, then give the pipe time to settle
    @(negedge clk);
    rx_if.valid <= 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && pending_results.size() != 0; w++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (pending_results.size() != 0)
      flag_result("result never came", pending_results.pop_front(), NO_RES);

    if (error_count == 0) begin
      $display("dle_stx_etx_frame_receiver: match");
    end else begin
      $display("dle_stx_etx_frame_receiver: mismatch");
    end
    $finish;
  end

endmodule
